### hw/rtl/rti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rti_pkg
// Widths, types and helpers shared by the ray / triangle intersection pipeline.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int COORD_BITS = 21;
  localparam int VEC_W      = 3 * COORD_BITS;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int CROSS_W    = 2 * DIFF_W + 1;
  localparam int LO_W       = (CROSS_W + 1) / 2;
  localparam int HI_W       = CROSS_W - LO_W;
  localparam int PLO_W      = DIFF_W + LO_W + 1;
  localparam int PHI_W      = DIFF_W + HI_W;
  localparam int PROD_W     = DIFF_W + CROSS_W;
  localparam int DOT_W      = PROD_W + 3;
  localparam int T_W        = 32;
  localparam int T_FRAC     = 16;
  localparam int SAT_W      = DOT_W + T_FRAC;
  localparam int DIV_W      = DOT_W + T_W;
  localparam int N_TERMS    = 12;
  localparam int N_DOTS     = 4;
  localparam logic [T_W-1:0] DIST_RESET = T_W'(7);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [CROSS_W-1:0]    cross_t;
  typedef logic signed [PLO_W-1:0]      plo_t;
  typedef logic signed [PHI_W-1:0]      phi_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [DOT_W-1:0]      dot_t;

  typedef struct packed {
    diff_t x;
    diff_t y;
    diff_t z;
  } dvec_t;

  typedef struct packed {
    cross_t x;
    cross_t y;
    cross_t z;
  } cvec_t;

  // edges and cross products handed from the front end to the dot stages
  typedef struct packed {
    dvec_t dir;
    dvec_t e1;
    dvec_t e2;
    dvec_t s;
    cvec_t h;
    cvec_t q;
  } front_t;

  // outcome of the bounds tests, carried alongside the divider
  typedef struct packed {
    logic in_tri;
    logic sat;
  } flag_t;

  function automatic dvec_t unpack_vec(logic [VEC_W-1:0] v);
    dvec_t  r;
    coord_t cx;
    coord_t cy;
    coord_t cz;
    cx  = v[3*COORD_BITS-1:2*COORD_BITS];
    cy  = v[2*COORD_BITS-1:COORD_BITS];
    cz  = v[COORD_BITS-1:0];
    r.x = diff_t'(cx);
    r.y = diff_t'(cy);
    r.z = diff_t'(cz);
    return r;
  endfunction

  function automatic dvec_t vsub(dvec_t a, dvec_t b);
    dvec_t r;
    r.x = a.x - b.x;
    r.y = a.y - b.y;
    r.z = a.z - b.z;
    return r;
  endfunction

  function automatic cvec_t cross_f(dvec_t a, dvec_t b);
    cvec_t r;
    logic signed [2*DIFF_W-1:0] p0;
    logic signed [2*DIFF_W-1:0] p1;
    logic signed [2*DIFF_W-1:0] p2;
    logic signed [2*DIFF_W-1:0] p3;
    logic signed [2*DIFF_W-1:0] p4;
    logic signed [2*DIFF_W-1:0] p5;
    p0  = a.y * b.z;
    p1  = a.z * b.y;
    p2  = a.z * b.x;
    p3  = a.x * b.z;
    p4  = a.x * b.y;
    p5  = a.y * b.x;
    r.x = cross_t'(p0) - cross_t'(p1);
    r.y = cross_t'(p2) - cross_t'(p3);
    r.z = cross_t'(p4) - cross_t'(p5);
    return r;
  endfunction

  function automatic plo_t mul_lo(diff_t a, cross_t c);
    logic signed [LO_W:0] l;
    l = $signed({1'b0, c[LO_W-1:0]});
    return a * l;
  endfunction

  function automatic phi_t mul_hi(diff_t a, cross_t c);
    logic signed [HI_W-1:0] hh;
    hh = c[CROSS_W-1:LO_W];
    return a * hh;
  endfunction

endpackage

### hw/rtl/rti_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rti_in_if
// Input channel: one ray and one triangle per item.
// ----------------------------------------------------------------------------
interface rti_in_if;
  import rti_pkg::*;

  logic             valid;
  logic             ready;
  logic [VEC_W-1:0] ray_origin;
  logic [VEC_W-1:0] ray_direction;
  logic [VEC_W-1:0] corner_a;
  logic [VEC_W-1:0] corner_b;
  logic [VEC_W-1:0] corner_c;

  modport source (
    output valid, ray_origin, ray_direction, corner_a, corner_b, corner_c,
    input  ready
  );
  modport sink (
    input  valid, ray_origin, ray_direction, corner_a, corner_b, corner_c,
    output ready
  );
endinterface

### hw/rtl/rti_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rti_out_if
// Result channel: hit flag and hit distance per item.
// ----------------------------------------------------------------------------
interface rti_out_if;
  import rti_pkg::*;

  logic           valid;
  logic           ready;
  logic           hit;
  logic [T_W-1:0] hit_distance;

  modport source (output valid, hit, hit_distance, input ready);
  modport sink (input valid, hit, hit_distance, output ready);
endinterface

### hw/rtl/rti_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rti_front
// Two stages: unpack and form the edges, then the two cross products.
// ----------------------------------------------------------------------------
module rti_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  logic                   valid_i,
  input  logic [rti_pkg::VEC_W-1:0] ray_origin_i,
  input  logic [rti_pkg::VEC_W-1:0] ray_direction_i,
  input  logic [rti_pkg::VEC_W-1:0] corner_a_i,
  input  logic [rti_pkg::VEC_W-1:0] corner_b_i,
  input  logic [rti_pkg::VEC_W-1:0] corner_c_i,
  output logic                   valid_o,
  output rti_pkg::front_t        front_o
);
  import rti_pkg::*;

  logic  v1_q;
  logic  v2_q;
  dvec_t dir1_q;
  dvec_t e11_q;
  dvec_t e21_q;
  dvec_t s1_q;
  front_t f2_q;
  dvec_t a_w;

  assign a_w = unpack_vec(corner_a_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dir1_q     <= unpack_vec(ray_direction_i);
      e11_q      <= vsub(unpack_vec(corner_b_i), a_w);
      e21_q      <= vsub(unpack_vec(corner_c_i), a_w);
      s1_q       <= vsub(unpack_vec(ray_origin_i), a_w);
      f2_q.dir   <= dir1_q;
      f2_q.e1    <= e11_q;
      f2_q.e2    <= e21_q;
      f2_q.s     <= s1_q;
      f2_q.h     <= cross_f(dir1_q, e21_q);
      f2_q.q     <= cross_f(s1_q, e11_q);
    end
  end

  assign valid_o = v2_q;
  assign front_o = f2_q;
endmodule

### hw/rtl/rti_dot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rti_dot
// Three stages: split partial products, recombined products, then the dot
// sums det, u, v and t numerators (in that lane order).
// ----------------------------------------------------------------------------
module rti_dot (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                valid_i,
  input  rti_pkg::front_t     front_i,
  output logic                valid_o,
  output rti_pkg::dot_t       det_o,
  output rti_pkg::dot_t       un_o,
  output rti_pkg::dot_t       vn_o,
  output rti_pkg::dot_t       tn_o
);
  import rti_pkg::*;

  diff_t  a_op [N_TERMS];
  cross_t c_op [N_TERMS];
  plo_t   lo_q [N_TERMS];
  phi_t   hi_q [N_TERMS];
  prod_t  prod_q [N_TERMS];
  dot_t   dot_q [N_DOTS];
  logic   v3_q;
  logic   v4_q;
  logic   v5_q;

  always_comb begin
    a_op[0]  = front_i.e1.x;  c_op[0]  = front_i.h.x;
    a_op[1]  = front_i.e1.y;  c_op[1]  = front_i.h.y;
    a_op[2]  = front_i.e1.z;  c_op[2]  = front_i.h.z;
    a_op[3]  = front_i.s.x;   c_op[3]  = front_i.h.x;
    a_op[4]  = front_i.s.y;   c_op[4]  = front_i.h.y;
    a_op[5]  = front_i.s.z;   c_op[5]  = front_i.h.z;
    a_op[6]  = front_i.dir.x; c_op[6]  = front_i.q.x;
    a_op[7]  = front_i.dir.y; c_op[7]  = front_i.q.y;
    a_op[8]  = front_i.dir.z; c_op[8]  = front_i.q.z;
    a_op[9]  = front_i.e2.x;  c_op[9]  = front_i.q.x;
    a_op[10] = front_i.e2.y;  c_op[10] = front_i.q.y;
    a_op[11] = front_i.e2.z;  c_op[11] = front_i.q.z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (adv_i) begin
      v3_q <= valid_i;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < N_TERMS; i++) begin
        lo_q[i]   <= mul_lo(a_op[i], c_op[i]);
        hi_q[i]   <= mul_hi(a_op[i], c_op[i]);
        prod_q[i] <= (prod_t'(hi_q[i]) <<< LO_W) + prod_t'(lo_q[i]);
      end
      for (int d = 0; d < N_DOTS; d++) begin
        dot_q[d] <= dot_t'(prod_q[3*d]) + dot_t'(prod_q[3*d+1]) + dot_t'(prod_q[3*d+2]);
      end
    end
  end

  assign valid_o = v5_q;
  assign det_o   = dot_q[0];
  assign un_o    = dot_q[1];
  assign vn_o    = dot_q[2];
  assign tn_o    = dot_q[3];
endmodule

### hw/rtl/rti_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rti_div
// Restoring divider, one quotient bit per stage, most significant bit first.
// ----------------------------------------------------------------------------
module rti_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  logic                     valid_i,
  input  logic [rti_pkg::DIV_W-1:0] num_i,
  input  logic [rti_pkg::DOT_W-1:0] det_i,
  input  rti_pkg::flag_t           flag_i,
  output logic                     valid_o,
  output logic [rti_pkg::T_W-1:0]  quo_o,
  output rti_pkg::flag_t           flag_o
);
  import rti_pkg::*;

  logic             valid_q [T_W];
  logic [T_W-1:0]   quo_q   [T_W];
  flag_t            flag_q  [T_W];
  logic [DIV_W-1:0] num_q   [T_W-1];
  logic [DOT_W-1:0] det_q   [T_W-1];

  for (genvar j = 0; j < T_W; j++) begin : g_stage
    localparam int K = T_W - 1 - j;
    logic             v_in;
    logic [DIV_W-1:0] n_in;
    logic [DOT_W-1:0] d_in;
    logic [T_W-1:0]   q_in;
    flag_t            f_in;
    logic [DIV_W-1:0] d_sh;
    logic             ge;

    if (j == 0) begin : g_first
      assign v_in = valid_i;
      assign n_in = num_i;
      assign d_in = det_i;
      assign q_in = '0;
      assign f_in = flag_i;
    end else begin : g_next
      assign v_in = valid_q[j-1];
      assign n_in = num_q[j-1];
      assign d_in = det_q[j-1];
      assign q_in = quo_q[j-1];
      assign f_in = flag_q[j-1];
    end

    assign d_sh = DIV_W'(d_in) << K;
    assign ge   = n_in >= d_sh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j] <= 1'b0;
      end else if (adv_i) begin
        valid_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        quo_q[j]  <= {q_in[T_W-2:0], ge};
        flag_q[j] <= f_in;
      end
    end

    if (j < T_W - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          num_q[j] <= ge ? n_in - d_sh : n_in;
          det_q[j] <= d_in;
        end
      end
    end
  end

  assign valid_o = valid_q[T_W-1];
  assign quo_o   = quo_q[T_W-1];
  assign flag_o  = flag_q[T_W-1];
endmodule

### hw/rtl/ray_triangle_intersect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Moller-Trumbore ray / triangle test in exact fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one ray (origin, direction) and one triangle (three corners)
//   per item; out_o returns hit and the Q16.16 distance t for each item, in
//   order. Both use valid/ready; an item moves when both are high.
//   cfg_we_i/cfg_wdata_i write min_distance; write it only while idle.
// Pipeline: from input acceptance to the result on out_o, the stages are
//   2 front, 3 dot product, 2 sign/bounds, 32 divider and 1 output register.
// Throughput: one item per cycle while out_o is not stalled; the 32-stage
//   quotient pipeline, one bit per stage, sets the depth.
// Stall: the whole pipeline advances together; when the output holds an
//   item that is not taken, every stage holds and in_i.ready drops, so
//   nothing is lost or repeated.
// Reset: clears all stage valid bits and sets min_distance to 7.
// ----------------------------------------------------------------------------
module ray_triangle_intersect (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  rti_in_if.sink                  in_i,
  rti_out_if.source               out_o,
  input  logic                    cfg_we_i,
  input  logic [rti_pkg::T_W-1:0] cfg_wdata_i
);
  import rti_pkg::*;

  logic           adv;
  logic [T_W-1:0] min_q;

  logic   fr_valid;
  front_t fr_data;
  logic   dt_valid;
  dot_t   det_w;
  dot_t   un_w;
  dot_t   vn_w;
  dot_t   tn_w;

  logic v6_q;
  logic zero6_q;
  dot_t det6_q;
  dot_t un6_q;
  dot_t vn6_q;
  dot_t tn6_q;

  logic             v7_q;
  flag_t            flag7_q;
  logic [DIV_W-1:0] num7_q;
  logic [DOT_W-1:0] det7_q;
  flag_t            flag_d;
  logic signed [DOT_W:0] uv_sum;

  logic           dv_valid;
  logic [T_W-1:0] dv_quo;
  flag_t          dv_flag;
  logic [T_W-1:0] t_d;
  logic           hit_d;

  logic           out_valid_q;
  logic           hit_q;
  logic [T_W-1:0] dist_q;

  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= DIST_RESET;
    end else if (cfg_we_i) begin
      min_q <= cfg_wdata_i;
    end
  end

  rti_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .valid_i         (in_i.valid),
    .ray_origin_i    (in_i.ray_origin),
    .ray_direction_i (in_i.ray_direction),
    .corner_a_i      (in_i.corner_a),
    .corner_b_i      (in_i.corner_b),
    .corner_c_i      (in_i.corner_c),
    .valid_o         (fr_valid),
    .front_o         (fr_data)
  );

  rti_dot u_dot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (fr_valid),
    .front_i (fr_data),
    .valid_o (dt_valid),
    .det_o   (det_w),
    .un_o    (un_w),
    .vn_o    (vn_w),
    .tn_o    (tn_w)
  );

  // fold the sign of det into the numerators
  always_ff @(posedge clk_i) begin
    if (adv) begin
      zero6_q <= det_w == '0;
      if (det_w < 0) begin
        det6_q <= -det_w;
        un6_q  <= -un_w;
        vn6_q  <= -vn_w;
        tn6_q  <= -tn_w;
      end else begin
        det6_q <= det_w;
        un6_q  <= un_w;
        vn6_q  <= vn_w;
        tn6_q  <= tn_w;
      end
    end
  end

  assign uv_sum = (DOT_W+1)'(un6_q) + (DOT_W+1)'(vn6_q);

  always_comb begin
    flag_d.in_tri = !zero6_q && (un6_q >= 0) && (un6_q <= det6_q) && (vn6_q >= 0) &&
                    (uv_sum <= (DOT_W+1)'(det6_q)) && (tn6_q >= 0);
    flag_d.sat    = $signed(SAT_W'(tn6_q)) >= ($signed(SAT_W'(det6_q)) <<< T_FRAC);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      flag7_q <= flag_d;
      num7_q  <= DIV_W'(tn6_q) << T_FRAC;
      det7_q  <= det6_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (adv) begin
      v6_q <= dt_valid;
      v7_q <= v6_q;
    end
  end

  rti_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (v7_q),
    .num_i   (num7_q),
    .det_i   (det7_q),
    .flag_i  (flag7_q),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .flag_o  (dv_flag)
  );

  always_comb begin
    t_d   = dv_flag.sat ? '1 : dv_quo;
    hit_d = dv_flag.in_tri && (t_d >= min_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_q  <= hit_d;
      dist_q <= hit_d ? t_d : '0;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.hit          = hit_q;
  assign out_o.hit_distance = dist_q;
endmodule
